/* hdl/assert_macros.svh */
// Assertion helpers; both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SZP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("szp assertion failed");
`define SZP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("szp assertion failed");
`else
`define SZP_ASSERT(lbl, prop)
`define SZP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* hdl/szp_pkg.sv */
package szp_pkg;

  localparam int BATCH_PAGES_DEF    = 64;
  localparam int MAX_PAGE_WORDS_DEF = 4096;

  localparam int DATA_W        = 64;
  localparam int PAGE_WORDS_W  = 13;
  localparam int LIMIT_W       = 40;
  localparam int RUN_WORDS_W   = 19;
  localparam int CFG_DATA_W    = 40;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [PAGE_WORDS_W-1:0] PAGE_WORDS_RST = 13'd512;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST      = '1;

  // Output queue; holds two runs of one word plus slack for the stage ahead.
  localparam int RUN_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W     = $clog2(RUN_FIFO_DEPTH);
  localparam int FILL_W         = $clog2(RUN_FIFO_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAGE_WORDS = 1'b0,
    CFG_CORE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    RUN_SKIP  = 1'b0,
    RUN_WRITE = 1'b1
  } run_kind_t;

  typedef struct packed {
    run_kind_t              kind;
    logic [RUN_WORDS_W-1:0] words;
    logic                   final_run;
    logic [LIMIT_W-1:0]     total;
  } run_t;

  // Runs produced by one word: cnt of them, filled from first.
  typedef struct packed {
    logic [1:0] cnt;
    run_t       first;
    run_t       second;
  } push_t;

endpackage

/* hdl/szp_in_if.sv */
interface szp_in_if;
  logic                        valid;
  logic                        ready;
  logic [szp_pkg::DATA_W-1:0]  data_word;
  logic                        last_word;

  modport source (output valid, output data_word, output last_word, input ready);
  modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

/* hdl/szp_out_if.sv */
interface szp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             run_kind;
  logic [szp_pkg::RUN_WORDS_W-1:0]  run_words;
  logic                             run_final;
  logic [szp_pkg::LIMIT_W-1:0]      total_words;

  modport source (output valid, output run_kind, output run_words, output run_final,
                  output total_words, input ready);
  modport sink   (input valid, input run_kind, input run_words, input run_final,
                  input total_words, output ready);
endinterface

/* hdl/sparse_zero_page_run_builder.sv */
// Sparse zero-page run builder.
// items: 64-bit dump words with a last_word flag, valid/ready, transfer when both high.
// runs:  run descriptors (skip or write, length in words, final flag, words so far),
//        valid/ready, one descriptor per transfer.
// cfg:   cfg_write/cfg_index/cfg_data set page_words (index 0) and core_limit_words
//        (index 1); write only while the block is idle.
// Throughput: one word per cycle while two queue slots are free. A word may yield up
//   to two descriptors; the descriptor queue drains one per cycle while runs.ready is
//   high, so a long stretch of two-descriptor words runs at the output rate.
// Path: a word is held in the input register, then the page/run update writes its
//   descriptors into the four-entry queue, from which they transfer.
// Reset (synchronous, rst high): page 512 words, limit 2^40-1, stream state cleared,
//   queue emptied.
// Output stall: the queue fills; the input register holds its word while fewer
//   than two queue slots are free, and items.ready is low while it holds a word.
`include "assert_macros.svh"

module sparse_zero_page_run_builder #(
  parameter int BATCH_PAGES    = szp_pkg::BATCH_PAGES_DEF,
  parameter int MAX_PAGE_WORDS = szp_pkg::MAX_PAGE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  szp_in_if.sink                          items,
  szp_out_if.source                       runs,
  input  logic                            cfg_write,
  input  logic [szp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [szp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import szp_pkg::*;

  logic              s_valid;
  logic              s_nz;
  logic              s_last;
  logic              advance;
  logic              room2;
  logic [FILL_W-1:0] fill;
  push_t             push;
  run_t              head;

  assign advance     = s_valid && room2;
  assign items.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (items.ready) begin
      s_valid <= items.valid;
    end
  end

  // Only the zero test of the word is needed downstream.
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s_nz   <= (items.data_word != '0);
      s_last <= items.last_word;
    end
  end

  szp_core #(
    .BATCH_PAGES    (BATCH_PAGES),
    .MAX_PAGE_WORDS (MAX_PAGE_WORDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .word_nz   (s_nz),
    .last_word (s_last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  szp_run_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rd_valid (runs.valid),
    .rd_ready (runs.ready),
    .rd_data  (head),
    .room2    (room2),
    .fill     (fill)
  );

  assign runs.run_kind    = head.kind;
  assign runs.run_words   = head.words;
  assign runs.run_final   = head.final_run;
  assign runs.total_words = head.total;

  `SZP_ASSERT(a_fill_bound, fill <= FILL_W'(RUN_FIFO_DEPTH))
  `SZP_ASSERT_NEXT(a_push_shows, push.cnt != 2'd0, runs.valid)
  `SZP_ASSERT_NEXT(a_stage_hold, s_valid && !advance, s_valid && $stable(s_nz) && $stable(s_last))
  `SZP_ASSERT(a_run_len, !runs.valid || runs.run_words != '0)
endmodule

/* hdl/szp_run_fifo.sv */
module szp_run_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  szp_pkg::push_t              push,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output szp_pkg::run_t               rd_data,
  output logic                        room2,
  output logic [szp_pkg::FILL_W-1:0]  fill
);
  import szp_pkg::*;

  run_t                  mem [RUN_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];
  assign room2    = (fill <= FILL_W'(RUN_FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.cnt);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      fill   <= fill + FILL_W'(push.cnt) - FILL_W'(pop);
    end
  end
endmodule

/* hdl/szp_core.sv */
module szp_core #(
  parameter int BATCH_PAGES    = szp_pkg::BATCH_PAGES_DEF,
  parameter int MAX_PAGE_WORDS = szp_pkg::MAX_PAGE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            word_nz,
  input  logic                            last_word,
  input  logic                            cfg_write,
  input  logic [szp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [szp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output szp_pkg::push_t                  push
);
  import szp_pkg::*;

  localparam int WIP_W = $clog2(MAX_PAGE_WORDS + 1);
  localparam int PIB_W = $clog2(BATCH_PAGES + 1);

  logic [PAGE_WORDS_W-1:0] page_words;
  logic [LIMIT_W-1:0]      core_limit_words;

  logic                   page_has_data, page_has_data_next;
  logic [WIP_W-1:0]       words_in_page, words_in_page_next;
  logic [PIB_W-1:0]       pages_in_batch, pages_in_batch_next;
  run_kind_t              open_run_kind, open_run_kind_next;
  logic [RUN_WORDS_W-1:0] open_run_words, open_run_words_next;
  logic [LIMIT_W-1:0]     accepted_words, accepted_words_next;
  logic                   limit_hit, limit_hit_next;

  logic                    take, closing, page_done, emit1, emit2, batch_end, has1;
  logic [WIP_W-1:0]        wip1;
  logic [PIB_W-1:0]        pib1;
  logic [LIMIT_W-1:0]      acc1;
  logic [PAGE_WORDS_W-1:0] psz;
  logic [RUN_WORDS_W-1:0]  orw_a, orw_b;
  run_kind_t               kind, ork_a;
  run_t                    r1, r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_words       <= PAGE_WORDS_RST;
      core_limit_words <= LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAGE_WORDS: page_words       <= cfg_data[PAGE_WORDS_W-1:0];
        CFG_CORE_LIMIT: core_limit_words <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Clamp page size into 1..MAX_PAGE_WORDS.
    if (page_words == '0) begin
      psz = PAGE_WORDS_W'(1);
    end else if (page_words > PAGE_WORDS_W'(MAX_PAGE_WORDS)) begin
      psz = PAGE_WORDS_W'(MAX_PAGE_WORDS);
    end else begin
      psz = page_words;
    end

    take      = (accepted_words < core_limit_words);
    acc1      = accepted_words + LIMIT_W'(take);
    has1      = page_has_data | (take & word_nz);
    wip1      = words_in_page + WIP_W'(take);
    closing   = !take || last_word || (acc1 >= core_limit_words);
    page_done = (PAGE_WORDS_W'(wip1) >= psz) || (closing && wip1 != '0);
    kind      = has1 ? RUN_WRITE : RUN_SKIP;

    // A page of the other kind ends the open run.
    emit1 = page_done && (open_run_words != '0) && (open_run_kind != kind);
    orw_a = emit1 ? '0 : open_run_words;
    ork_a = (page_done && orw_a == '0) ? kind : open_run_kind;
    orw_b = page_done ? orw_a + RUN_WORDS_W'(wip1) : orw_a;
    pib1  = pages_in_batch + PIB_W'(page_done);

    batch_end = (pib1 >= PIB_W'(BATCH_PAGES)) || closing;
    emit2     = batch_end && (orw_b != '0);

    r1 = '{kind: open_run_kind, words: open_run_words, final_run: 1'b0, total: acc1};
    r2 = '{kind: ork_a, words: orw_b, final_run: closing, total: acc1};

    page_has_data_next  = page_has_data;
    words_in_page_next  = words_in_page;
    pages_in_batch_next = pages_in_batch;
    open_run_kind_next  = open_run_kind;
    open_run_words_next = open_run_words;
    accepted_words_next = accepted_words;
    limit_hit_next      = limit_hit;
    push.cnt            = 2'd0;
    push.first          = emit1 ? r1 : r2;
    push.second         = r2;

    if (advance) begin
      if (limit_hit) begin
        // Drop everything until the end of the stream.
        if (last_word) begin
          limit_hit_next      = 1'b0;
          accepted_words_next = '0;
        end
      end else begin
        push.cnt            = 2'(emit1) + 2'(emit2);
        page_has_data_next  = page_done ? 1'b0 : has1;
        words_in_page_next  = page_done ? '0 : wip1;
        pages_in_batch_next = batch_end ? '0 : pib1;
        open_run_kind_next  = batch_end ? RUN_SKIP : ork_a;
        open_run_words_next = batch_end ? '0 : orw_b;
        accepted_words_next = acc1;
        if (closing) begin
          if (last_word) begin
            accepted_words_next = '0;
            limit_hit_next      = 1'b0;
          end else begin
            limit_hit_next      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_has_data  <= 1'b0;
      words_in_page  <= '0;
      pages_in_batch <= '0;
      open_run_kind  <= RUN_SKIP;
      open_run_words <= '0;
      accepted_words <= '0;
      limit_hit      <= 1'b0;
    end else begin
      page_has_data  <= page_has_data_next;
      words_in_page  <= words_in_page_next;
      pages_in_batch <= pages_in_batch_next;
      open_run_kind  <= open_run_kind_next;
      open_run_words <= open_run_words_next;
      accepted_words <= accepted_words_next;
      limit_hit      <= limit_hit_next;
    end
  end
endmodule

/* bench/sparse_zero_page_run_builder_tb.sv */
`timescale 1ns / 1ps

module sparse_zero_page_run_builder_tb;
  import szp_pkg::*;

  localparam int RAND_ITEMS   = 1000;
  localparam int DRAIN_CYCLES = 6;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_PAGE,
    ROW_LIMIT
  } row_op_t;

  // n_typed < 0: take the expected runs from the predictor
  typedef struct packed {
    row_op_t     op;
    logic [63:0] data;
    logic        last;
    int          n_typed;
    run_t        r0;
    run_t        r1;
  } stim_row_t;

  localparam run_t NO_RUN = '0;
  localparam int DIR_ROWS = 27;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_WORD, 64'h0, 1'b1, 1, '{RUN_SKIP, 19'd1, 1'b1, 40'd1}, NO_RUN},
    '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1, '{RUN_WRITE, 19'd1, 1'b1, 40'd1}, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b0, 0, NO_RUN, NO_RUN},
    // page size zero, lowered under a partial page
    '{ROW_PAGE, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h8000_0000_0000_0000, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b1, -1, NO_RUN, NO_RUN},
    // page size above the maximum
    '{ROW_PAGE, 64'h1FFF, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h1, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b1, -1, NO_RUN, NO_RUN},
    // limit zero: drop closes an empty stream
    '{ROW_LIMIT, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h5, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h7, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b1, -1, NO_RUN, NO_RUN},
    // limit reached on a short page: two runs from one word
    '{ROW_LIMIT, 64'h3, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_PAGE, 64'h2, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h1234, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b1, -1, NO_RUN, NO_RUN},
    // limit lowered below the words already taken
    '{ROW_LIMIT, 64'hFF_FFFF_FFFF, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h1, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_LIMIT, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b0, -1, NO_RUN, NO_RUN},
    '{ROW_WORD, 64'h0, 1'b1, -1, NO_RUN, NO_RUN},
    '{ROW_LIMIT, 64'hFF_FFFF_FFFF, 1'b0, -1, NO_RUN, NO_RUN}
  };

  logic     clk;
  logic     rst;
  logic     cfg_write;
  cfg_reg_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  szp_in_if  items_if ();
  szp_out_if runs_if ();

  sparse_zero_page_run_builder dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .runs      (runs_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state and register copies
  logic [PAGE_WORDS_W-1:0] cfg_page     = PAGE_WORDS_RST;
  logic [LIMIT_W-1:0]      cfg_limit    = LIMIT_RST;
  bit                      pg_data      = 1'b0;
  int unsigned             pg_fill      = 0;
  int unsigned             batch_pages  = 0;
  run_kind_t               open_kind    = RUN_SKIP;
  int unsigned             open_len     = 0;
  logic [LIMIT_W-1:0]      acc_words    = '0;
  bit                      limit_closed = 1'b0;

  run_t pending_runs[$];
  run_t want;
  int   mismatches = 0;
  int   rx_gap     = 0;
  bit   no_idle    = 1'b0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[sparse_zero_page_run_builder] ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic run_t open_run_desc(input bit fin);
    run_t r;
    r.kind      = open_kind;
    r.words     = RUN_WORDS_W'(open_len);
    r.final_run = fin;
    r.total     = acc_words;
    return r;
  endfunction

  task automatic predict_runs(input logic [63:0] w, input bit lst, ref run_t runs_out[$]);
    bit          closing;
    int unsigned psz;
    run_kind_t   kind;
    // after a close by the limit, drop everything up to the last word
    if (limit_closed) begin
      if (lst) begin
        limit_closed = 1'b0;
        acc_words    = '0;
      end
      return;
    end
    closing = 1'b1;
    if (acc_words < cfg_limit) begin
      acc_words = acc_words + 1'b1;
      if (w != '0) pg_data = 1'b1;
      pg_fill++;
      closing = lst || (acc_words >= cfg_limit);
    end
    psz = 32'(cfg_page);
    if (psz == 0) psz = 1;
    if (psz > MAX_PAGE_WORDS_DEF) psz = MAX_PAGE_WORDS_DEF;
    if (pg_fill >= psz || (closing && pg_fill > 0)) begin
      kind = pg_data ? RUN_WRITE : RUN_SKIP;
      if (open_len != 0 && open_kind != kind) begin
        runs_out.push_back(open_run_desc(1'b0));
        open_len = 0;
      end
      if (open_len == 0) open_kind = kind;
      open_len += pg_fill;
      batch_pages++;
      pg_fill = 0;
      pg_data = 1'b0;
    end
    if (batch_pages >= BATCH_PAGES_DEF || closing) begin
      if (open_len != 0) runs_out.push_back(open_run_desc(closing));
      open_len    = 0;
      open_kind   = RUN_SKIP;
      batch_pages = 0;
    end
    if (closing) begin
      if (lst) acc_words = '0;
      limit_closed = !lst;
    end
  endtask

  task automatic settle();
    items_if.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LIMIT_W-1:0] val);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_PAGE_WORDS) cfg_page = val[PAGE_WORDS_W-1:0];
    else cfg_limit = val;
  endtask

  task automatic drive_word(input logic [63:0] w, input bit lst, input int n_typed,
                            input run_t t0, input run_t t1);
    int   gap;
    run_t fresh[$];
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid     <= 1'b1;
    items_if.data_word <= w;
    items_if.last_word <= lst;
    do @(posedge clk); while (!items_if.ready);
    predict_runs(w, lst, fresh);
    if (n_typed < 0) begin
      foreach (fresh[i]) pending_runs.push_back(fresh[i]);
    end else begin
      if (n_typed > 0) pending_runs.push_back(t0);
      if (n_typed > 1) pending_runs.push_back(t1);
    end
  endtask

  // Run sink: random stall after each transfer, compare with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      runs_if.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (runs_if.valid && runs_if.ready) begin
        if (pending_runs.size() == 0) begin
          flag_mismatch($sformatf("unexpected run kind=%0d words=%0d final=%0d total=%0d",
                                  runs_if.run_kind, runs_if.run_words, runs_if.run_final,
                                  runs_if.total_words));
        end else begin
          want = pending_runs.pop_front();
          if (runs_if.run_kind !== want.kind)
            flag_mismatch($sformatf("run_kind got %0d want %0d",
                                    runs_if.run_kind, want.kind));
          if (runs_if.run_words !== want.words)
            flag_mismatch($sformatf("run_words got %0d want %0d",
                                    runs_if.run_words, want.words));
          if (runs_if.run_final !== want.final_run)
            flag_mismatch($sformatf("run_final got %0d want %0d",
                                    runs_if.run_final, want.final_run));
          if (runs_if.total_words !== want.total)
            flag_mismatch($sformatf("total_words got %0d want %0d",
                                    runs_if.total_words, want.total));
        end
        rx_gap = no_idle ? 0 : $urandom_range(0, 14);
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
      end
      runs_if.ready <= (rx_gap == 0);
    end
  end

  initial begin : stimulus
    int          counted;
    int          stream_left;
    int          seg;
    int          spins;
    int          pick;
    bit          data_zone;
    bit          lst;
    logic [63:0] w;
    logic [LIMIT_W-1:0] lim;

    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = CFG_PAGE_WORDS;
    cfg_data           = '0;
    items_if.valid     = 1'b0;
    items_if.data_word = '0;
    items_if.last_word = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_PAGE:  write_reg(CFG_PAGE_WORDS, dir_rows[i].data[LIMIT_W-1:0]);
        ROW_LIMIT: write_reg(CFG_CORE_LIMIT, dir_rows[i].data[LIMIT_W-1:0]);
        default:   drive_word(dir_rows[i].data, dir_rows[i].last, dir_rows[i].n_typed,
                              dir_rows[i].r0, dir_rows[i].r1);
      endcase
    end

    counted     = 0;
    stream_left = $urandom_range(1, 150);
    data_zone   = 1'b0;
    while (counted < RAND_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        // mostly small pages; a few at and beyond the maximum
        pick = $urandom_range(0, 19);
        if (pick < 8) lim = LIMIT_W'($urandom_range(1, 4));
        else if (pick < 13) lim = LIMIT_W'($urandom_range(5, 16));
        else if (pick < 15) lim = LIMIT_W'($urandom_range(17, 200));
        else if (pick == 15) lim = '0;
        else if (pick == 16) lim = LIMIT_W'(MAX_PAGE_WORDS_DEF);
        else if (pick == 17) lim = LIMIT_W'(13'h1FFF);
        else if (pick == 18) lim = LIMIT_W'($urandom_range(MAX_PAGE_WORDS_DEF + 1, 8191));
        else lim = LIMIT_W'($urandom_range(201, MAX_PAGE_WORDS_DEF - 1));
        write_reg(CFG_PAGE_WORDS, lim);
      end
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) lim = LIMIT_RST;
        else if (pick < 7) lim = acc_words + LIMIT_W'($urandom_range(0, 40));
        else if (pick == 7)
          lim = (acc_words > 0) ?
                LIMIT_W'($urandom_range(0, 32'(acc_words - 1'b1))) : '0;
        else if (pick == 8) lim = '0;
        else lim = {8'($urandom_range(0, 255)), 32'($urandom)};
        write_reg(CFG_CORE_LIMIT, lim);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      seg     = $urandom_range(20, 120);
      repeat (seg) begin
        if ($urandom_range(0, 5) == 0) data_zone = !data_zone;
        if (data_zone) begin
          case ($urandom_range(0, 15))
            0:       w = '0;
            1:       w = '1;
            default: w = {$urandom, $urandom};
          endcase
        end else begin
          // zero stretch with an odd sparse word anywhere in a page
          w = '0;
          if ($urandom_range(0, 29) == 0) w = 64'd1 << $urandom_range(0, 63);
        end
        if (stream_left > 0) stream_left--;
        lst = (stream_left == 0) || ($urandom_range(0, 79) == 0) ||
              (limit_closed && $urandom_range(0, 3) == 0);
        if (lst) stream_left = $urandom_range(1, 150);
        if (!limit_closed) counted++;
        drive_word(w, lst, -1, NO_RUN, NO_RUN);
      end
    end

    items_if.valid <= 1'b0;
    spins = 0;
    while (pending_runs.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (pending_runs.size() != 0)
      flag_mismatch($sformatf("%0d runs never arrived", pending_runs.size()));
    if (mismatches == 0) begin
      $display("[sparse_zero_page_run_builder] OK");
    end else begin
      $display("[sparse_zero_page_run_builder] ERROR");
    end
    $finish;
  end

endmodule
